// ----- design/maes_pkg.sv -----
// Mini-AES package: constants, S-boxes and round functions.
package maes_pkg;

  localparam int          NUM_ROUNDS_DEFAULT = 2;
  localparam logic [15:0] KEY_RESET          = 16'hC3F0;
  localparam logic [4:0]  GF_POLY            = 5'b10011;
  localparam logic        OP_ENCRYPT         = 1'b0;
  localparam logic        OP_DECRYPT         = 1'b1;

  typedef logic [15:0] block_t;
  typedef logic [3:0]  nibble_t;

  function automatic nibble_t sbox_fwd(input nibble_t a);
    nibble_t r;
    case (a)
      4'h0: r = 4'hE;
      4'h1: r = 4'h4;
      4'h2: r = 4'hD;
      4'h3: r = 4'h1;
      4'h4: r = 4'h2;
      4'h5: r = 4'hF;
      4'h6: r = 4'hB;
      4'h7: r = 4'h8;
      4'h8: r = 4'h3;
      4'h9: r = 4'hA;
      4'hA: r = 4'h6;
      4'hB: r = 4'hC;
      4'hC: r = 4'h5;
      4'hD: r = 4'h9;
      4'hE: r = 4'h0;
      default: r = 4'h7;
    endcase
    return r;
  endfunction

  function automatic nibble_t sbox_inv(input nibble_t a);
    nibble_t r;
    case (a)
      4'h0: r = 4'hE;
      4'h1: r = 4'h3;
      4'h2: r = 4'h4;
      4'h3: r = 4'h8;
      4'h4: r = 4'h1;
      4'h5: r = 4'hC;
      4'h6: r = 4'hA;
      4'h7: r = 4'hF;
      4'h8: r = 4'h7;
      4'h9: r = 4'hD;
      4'hA: r = 4'h9;
      4'hB: r = 4'h6;
      4'hC: r = 4'hB;
      4'hD: r = 4'h2;
      4'hE: r = 4'h0;
      default: r = 4'h5;
    endcase
    return r;
  endfunction

  function automatic block_t sub_fwd(input block_t w);
    return {sbox_fwd(w[15:12]), sbox_fwd(w[11:8]), sbox_fwd(w[7:4]), sbox_fwd(w[3:0])};
  endfunction

  function automatic block_t sub_inv(input block_t w);
    return {sbox_inv(w[15:12]), sbox_inv(w[11:8]), sbox_inv(w[7:4]), sbox_inv(w[3:0])};
  endfunction

  // n1 and n3 trade places
  function automatic block_t swap_row(input block_t w);
    return {w[15:12], w[3:0], w[7:4], w[11:8]};
  endfunction

  function automatic nibble_t gf_x2(input nibble_t a);
    logic [4:0] t;
    t = {a, 1'b0};
    if (t[4]) begin
      t = t ^ GF_POLY;
    end
    return t[3:0];
  endfunction

  function automatic nibble_t gf_x3(input nibble_t a);
    return gf_x2(a) ^ a;
  endfunction

  // columns (n0,n1), (n2,n3) times [[3,2],[2,3]]
  function automatic block_t mix_cols(input block_t w);
    return {gf_x3(w[15:12]) ^ gf_x2(w[11:8]),
            gf_x2(w[15:12]) ^ gf_x3(w[11:8]),
            gf_x3(w[7:4])   ^ gf_x2(w[3:0]),
            gf_x2(w[7:4])   ^ gf_x3(w[3:0])};
  endfunction

  // one key schedule step; rc_sel picks rcon = 1 << rc_sel
  function automatic block_t key_step(input block_t p, input logic [1:0] rc_sel);
    nibble_t w0;
    nibble_t w1;
    nibble_t w2;
    nibble_t w3;
    w0 = p[15:12] ^ sbox_fwd(p[3:0]) ^ (4'b0001 << rc_sel);
    w1 = p[11:8] ^ w0;
    w2 = p[7:4] ^ w1;
    w3 = p[3:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

// ----- design/mini_aes_block_cipher_top.sv -----
// Mini-AES 16-bit block cipher, one registered pass per item.
// Each item is held in the input register and then in the result register, so
// the block accepts an item every cycle when the output side does not stall. All
// rounds of one item are computed in one pass of logic between those two
// registers; round keys are expanded and stored when the key is written (and at
// reset, from 0xC3F0).
// tuser bit 0 selects encrypt (0) or decrypt (1).
module mini_aes_block_cipher_top #(
  parameter int NUM_ROUNDS = maes_pkg::NUM_ROUNDS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data,       // cipher_key
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // data_block
  input  logic        s_axis_tuser,   // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // result_block
);

  maes_pkg::block_t round_key [NUM_ROUNDS+1];
  maes_pkg::block_t key_chain [NUM_ROUNDS+1];

  logic             valid1;
  logic             op1;
  maes_pkg::block_t blk1;
  logic             adv1;
  logic             adv2;

  maes_pkg::block_t enc_st [NUM_ROUNDS];
  maes_pkg::block_t dec_st [NUM_ROUNDS];
  maes_pkg::block_t enc_out;
  maes_pkg::block_t dec_out;
  maes_pkg::block_t result;

  // key schedule
  assign key_chain[0] = rst ? maes_pkg::KEY_RESET : cfg_data;
  for (genvar r = 1; r <= NUM_ROUNDS; r++) begin : g_keys
    assign key_chain[r] = maes_pkg::key_step(key_chain[r-1], 2'((r - 1) % 4));
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      round_key <= key_chain;
    end
  end

  // encrypt path
  assign enc_st[0] = blk1 ^ round_key[0];
  for (genvar r = 1; r < NUM_ROUNDS; r++) begin : g_enc
    assign enc_st[r] = maes_pkg::mix_cols(maes_pkg::swap_row(maes_pkg::sub_fwd(enc_st[r-1])))
                       ^ round_key[r];
  end
  assign enc_out = maes_pkg::swap_row(maes_pkg::sub_fwd(enc_st[NUM_ROUNDS-1]))
                   ^ round_key[NUM_ROUNDS];

  // decrypt path
  assign dec_st[0] = blk1 ^ round_key[NUM_ROUNDS];
  for (genvar r = 1; r < NUM_ROUNDS; r++) begin : g_dec
    assign dec_st[r] = maes_pkg::mix_cols(maes_pkg::swap_row(maes_pkg::sub_inv(dec_st[r-1]))
                       ^ round_key[NUM_ROUNDS-r]);
  end
  assign dec_out = maes_pkg::swap_row(maes_pkg::sub_inv(dec_st[NUM_ROUNDS-1]))
                   ^ round_key[0];

  assign result = (op1 == maes_pkg::OP_DECRYPT) ? dec_out : enc_out;

  // flow control
  assign adv2          = !m_axis_tvalid || m_axis_tready;
  assign adv1          = !valid1 || adv2;
  assign s_axis_tready = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (adv1) begin
      valid1 <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && s_axis_tvalid) begin
      op1  <= s_axis_tuser;
      blk1 <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv2) begin
      m_axis_tvalid <= valid1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && valid1) begin
      m_axis_tdata <= result;
    end
  end

`ifndef SYNTHESIS
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_axis_tvalid && !valid1)
    else $error("pipeline valid not cleared by reset");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    valid1 && m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while pipeline is full");

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> valid1)
    else $error("accepted item not held in input register");

  a_result_loads: assert property (@(posedge clk) disable iff (rst)
    adv2 && valid1 |=> m_axis_tvalid && m_axis_tdata == $past(result))
    else $error("result register not loaded with computed block");
`endif

endmodule

// ----- sim/mini_aes_block_cipher_checker.sv -----
// Mini-AES stream checker: tracks the key, predicts each result block and compares it.
`timescale 1ns / 100ps

module mini_aes_block_cipher_checker #(
  parameter int NUM_ROUNDS = maes_pkg::NUM_ROUNDS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  maes_pkg::block_t cfg_data,
  input  logic             s_axis_tvalid,
  input  logic             s_axis_tready,
  input  maes_pkg::block_t s_axis_tdata,
  input  logic             s_axis_tuser,
  input  logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  input  maes_pkg::block_t m_axis_tdata,
  output int               fail_count,
  output int               blocks_in_flight
);

  // S-box tables, entry i in bits 4*i+3:4*i
  localparam logic [63:0] SUB_TAB_FWD = 64'h7095_C6A3_8BF2_1D4E;
  localparam logic [63:0] SUB_TAB_INV = 64'h502B_69D7_FAC1_843E;

  maes_pkg::block_t round_key [0:NUM_ROUNDS];
  maes_pkg::block_t cipher_results [$];

  function automatic maes_pkg::block_t sub_nibbles(input maes_pkg::block_t w,
                                                   input logic [63:0] tab);
    maes_pkg::block_t r;
    for (int i = 0; i < 4; i++) begin
      r[4*i +: 4] = tab[4*w[4*i +: 4] +: 4];
    end
    return r;
  endfunction

  function automatic maes_pkg::block_t rotate_row(input maes_pkg::block_t w);
    return {w[15:12], w[3:0], w[7:4], w[11:8]};
  endfunction

  function automatic maes_pkg::nibble_t gf_dbl(input maes_pkg::nibble_t a);
    return {a[2:0], 1'b0} ^ (a[3] ? 4'h3 : 4'h0);
  endfunction

  function automatic maes_pkg::block_t mix_pairs(input maes_pkg::block_t w);
    maes_pkg::block_t r;
    maes_pkg::nibble_t hi;
    maes_pkg::nibble_t lo;
    for (int c = 0; c < 2; c++) begin
      hi = w[8*c+4 +: 4];
      lo = w[8*c +: 4];
      r[8*c+4 +: 4] = gf_dbl(hi) ^ hi ^ gf_dbl(lo);
      r[8*c +: 4]   = gf_dbl(hi) ^ gf_dbl(lo) ^ lo;
    end
    return r;
  endfunction

  function automatic void load_round_keys(input maes_pkg::block_t k);
    maes_pkg::block_t p;
    maes_pkg::nibble_t w0;
    maes_pkg::nibble_t w1;
    maes_pkg::nibble_t w2;
    maes_pkg::nibble_t w3;
    round_key[0] = k;
    for (int i = 1; i <= NUM_ROUNDS; i++) begin
      p = round_key[i-1];
      w0 = p[15:12] ^ SUB_TAB_FWD[4*p[3:0] +: 4] ^ maes_pkg::nibble_t'(1 << ((i - 1) % 4));
      w1 = p[11:8] ^ w0;
      w2 = p[7:4] ^ w1;
      w3 = p[3:0] ^ w2;
      round_key[i] = {w0, w1, w2, w3};
    end
  endfunction

  function automatic maes_pkg::block_t cipher_block(input logic op,
                                                    input maes_pkg::block_t blk);
    maes_pkg::block_t b;
    if (op == maes_pkg::OP_DECRYPT) begin
      b = blk ^ round_key[NUM_ROUNDS];
      for (int r = NUM_ROUNDS - 1; r > 0; r--) begin
        b = mix_pairs(rotate_row(sub_nibbles(b, SUB_TAB_INV)) ^ round_key[r]);
      end
      b = rotate_row(sub_nibbles(b, SUB_TAB_INV)) ^ round_key[0];
    end else begin
      b = blk ^ round_key[0];
      for (int r = 1; r < NUM_ROUNDS; r++) begin
        b = mix_pairs(rotate_row(sub_nibbles(b, SUB_TAB_FWD))) ^ round_key[r];
      end
      b = rotate_row(sub_nibbles(b, SUB_TAB_FWD)) ^ round_key[NUM_ROUNDS];
    end
    return b;
  endfunction

  always @(posedge clk) begin
    maes_pkg::block_t want;
    if (rst) begin
      cipher_results.delete();
      load_round_keys(maes_pkg::KEY_RESET);
      fail_count <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (cipher_results.size() == 0) begin
          $display("%0t: unexpected result item, expected none, got %h",
                   $time, m_axis_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = cipher_results.pop_front();
          if (m_axis_tdata !== want) begin
            $display("%0t: result_block mismatch, expected %h, got %h",
                     $time, want, m_axis_tdata);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        cipher_results.push_back(cipher_block(s_axis_tuser, s_axis_tdata));
      end
      if (cfg_write) begin
        load_round_keys(cfg_data);
      end
    end
    blocks_in_flight <= cipher_results.size();
  end

endmodule

// ----- sim/mini_aes_block_cipher_top_tb.sv -----
// Mini-AES testbench top: clock, reset, key writes, block stimulus, sink stalls, verdict.
`timescale 1ns / 100ps

module mini_aes_block_cipher_top_tb;

  localparam int   KEY_PHASES   = 33;
  localparam int   PHASE_BLOCKS = 50;
  localparam int   DRAIN_CYCLES = 8;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_write;
  maes_pkg::block_t cfg_data;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  maes_pkg::block_t s_axis_tdata;   // data_block
  logic             s_axis_tuser;   // operation
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  maes_pkg::block_t m_axis_tdata;   // result_block

  int fail_count;
  int blocks_in_flight;
  bit quiet;
  int stall_left;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  mini_aes_block_cipher_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  mini_aes_block_cipher_checker checker_i (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_data         (cfg_data),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .fail_count       (fail_count),
    .blocks_in_flight (blocks_in_flight)
  );

  // mostly no gap, some short, a few long
  function automatic int idle_gap();
    int r;
    if (quiet) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 88) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(6, 24);
  endfunction

  function automatic maes_pkg::block_t pick_block();
    maes_pkg::block_t b;
    case ($urandom_range(0, 15))
      0:       b = 16'h0000;
      1:       b = 16'hFFFF;
      2:       b = maes_pkg::block_t'(1) << $urandom_range(0, 15);
      3:       b = ~(maes_pkg::block_t'(1) << $urandom_range(0, 15));
      default: b = maes_pkg::block_t'($urandom);
    endcase
    return b;
  endfunction

  task automatic send_block(input logic op, input maes_pkg::block_t blk);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= blk;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (blocks_in_flight != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_key(input maes_pkg::block_t k);
    drain();
    cfg_write <= 1'b1;
    cfg_data  <= k;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // output side stalls
  initial begin
    m_axis_tready = 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!quiet && $urandom_range(0, 3) == 0) begin
          stall_left = idle_gap();
        end
      end
    end
  end

  initial begin
    maes_pkg::block_t k;
    rst           = 1'b1;
    quiet         = 1'b0;
    cfg_write     = 1'b0;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = maes_pkg::OP_ENCRYPT;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset key, known vector and field extremes
    send_block(maes_pkg::OP_ENCRYPT, 16'h9C63);
    send_block(maes_pkg::OP_DECRYPT, 16'h72C6);
    send_block(maes_pkg::OP_ENCRYPT, 16'h0000);
    send_block(maes_pkg::OP_DECRYPT, 16'h0000);
    send_block(maes_pkg::OP_ENCRYPT, 16'hFFFF);
    send_block(maes_pkg::OP_DECRYPT, 16'hFFFF);
    send_block(maes_pkg::OP_ENCRYPT, 16'h8000);
    send_block(maes_pkg::OP_DECRYPT, 16'h0001);
    send_block(maes_pkg::OP_ENCRYPT, 16'hA5A5);
    send_block(maes_pkg::OP_DECRYPT, 16'h5A5A);
    send_block(maes_pkg::OP_ENCRYPT, 16'h0123);
    send_block(maes_pkg::OP_ENCRYPT, 16'h4567);
    send_block(maes_pkg::OP_DECRYPT, 16'h89AB);
    send_block(maes_pkg::OP_DECRYPT, 16'hCDEF);
    load_key(16'hFFFF);
    send_block(maes_pkg::OP_ENCRYPT, 16'h0000);
    send_block(maes_pkg::OP_DECRYPT, 16'hFFFF);
    send_block(maes_pkg::OP_ENCRYPT, 16'hF00F);
    send_block(maes_pkg::OP_DECRYPT, 16'h0FF0);

    for (int ph = 0; ph < KEY_PHASES; ph++) begin
      case (ph)
        0:       k = 16'h0000;
        1:       k = 16'hFFFF;
        2:       k = maes_pkg::KEY_RESET;
        3:       k = 16'h8000;
        4:       k = 16'h0001;
        default: k = maes_pkg::block_t'($urandom);
      endcase
      load_key(k);
      quiet = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_BLOCKS; n++) begin
        send_block(logic'($urandom_range(0, 1)), pick_block());
      end
    end
    quiet = 1'b0;

    drain();
    if (fail_count == 0) begin
      $display("mini_aes_block_cipher_top_tb: done, clean");
    end else begin
      $display("mini_aes_block_cipher_top_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("mini_aes_block_cipher_top_tb: done, errors");
    $finish;
  end

endmodule
